// File: design/hub75_scan_sequencer_core_defines.svh
// Assertion macros for the scan sequencer core.
`ifndef HUB75_SCAN_SEQUENCER_CORE_DEFINES_SVH
`define HUB75_SCAN_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HSS_ASSERT_NOW(name_, ante_, cons_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante_) |-> (cons_)) else $error(msg_);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HSS_ASSERT_NEXT(name_, ante_, cons_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante_) |=> (cons_)) else $error(msg_);

`endif

// File: design/hss_pkg.sv
// Shared types and constants for the scan sequencer core.
`timescale 1ns / 1ps

package hss_pkg;

  localparam int ROW_LENGTH = 128;
  localparam int ROW_COUNT  = 8;

  localparam int ColW      = $clog2(ROW_LENGTH + 1);
  localparam int InitStepW = $clog2(3 * ROW_LENGTH + 1);
  localparam int RowW      = 3;
  localparam int WinW      = 9;
  localparam int BrightW   = 8;

  // Driver set-up patterns, bit i is step i of each 16-step period.
  localparam logic [15:0] RegOnePattern = 16'h07E0;
  localparam logic [15:0] RegTwoPattern = 16'h0200;

  // Lit window = WinBase + brightness * WinScale / WinDiv.
  localparam int WinBase        = 8;
  localparam int WinScale       = 400;
  localparam int WinDiv         = 255;
  localparam int WinRecip       = 257;
  localparam int WinRecipShift  = 16;
  localparam int BrightReset    = 128;
  localparam logic [WinW-1:0] WinResetLen =
      WinW'(WinBase + (BrightReset * WinScale) / WinDiv);

  localparam logic [1:0] ActShift = 2'd0;
  localparam logic [1:0] ActTick  = 2'd1;
  localparam logic [1:0] ActInit  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] upper_color;
    logic [2:0] lower_color;
  } in_item_t;

  typedef struct packed {
    logic [2:0] upper_rgb;
    logic [2:0] lower_rgb;
    logic [2:0] row_address;
    logic       clock_pulse;
    logic       latch_level;
    logic       latch_pulse;
    logic       output_blank;
    logic [1:0] phase;
    logic       frame_done;
    logic       rejected;
  } out_item_t;

endpackage

// File: design/hub75_scan_sequencer_core.sv
// Top level of the HUB75 scan sequencer: pin step per transaction.
// A result is registered in the output register when its item is taken.
// Throughput: one item per cycle while in_stall_o is low; the single pass from input to output register sets it.
// in_stall_o rises only while a held result is stalled by out_stall_i.
// Reset: phase shifting, panel blanked, row 0, brightness 128 (lit window 208 ticks).
`timescale 1ns / 1ps

`include "hub75_scan_sequencer_core_defines.svh"

module hub75_scan_sequencer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  hss_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output hss_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hss_pkg::BrightW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    PhInit  = 2'd0,
    PhShift = 2'd1,
    PhFull  = 2'd2,
    PhLit   = 2'd3
  } phase_e;

  localparam int ColW  = hss_pkg::ColW;
  localparam int StepW = hss_pkg::InitStepW;
  localparam int RowW  = hss_pkg::RowW;
  localparam int WinW  = hss_pkg::WinW;

  phase_e                 phase_q, phase_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [ColW-1:0]        col_q, col_d;
  logic [RowW-1:0]        row_q, row_d;
  logic [WinW-1:0]        lit_cnt_q, lit_cnt_d;
  logic [5:0]             data_q, data_d;
  logic                   latch_q, latch_d;
  logic                   blank_q, blank_d;
  logic [WinW-1:0]        win_len_q, win_len_d;
  logic                   out_valid_q;
  hss_pkg::out_item_t     out_item_q, out_item_d;

  logic                   accept;
  logic                   clk_pulse, lat_pulse, frame_done, rejected;
  logic [StepW-1:0]       step_rel;
  logic [ColW-1:0]        col_inc;
  logic [RowW:0]          row_inc;
  logic [WinW-1:0]        lit_dec;

  logic [16:0]            win_prod;
  logic [25:0]            win_est;
  logic [WinW-1:0]        win_quo;
  logic [16:0]            win_rem;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Lit window from the new brightness: reciprocal estimate, then one correction.
  always_comb begin
    win_prod  = 17'(cfg_data_i) * 17'(hss_pkg::WinScale);
    win_est   = 26'(win_prod) * 26'(hss_pkg::WinRecip);
    win_quo   = win_est[hss_pkg::WinRecipShift +: WinW];
    win_rem   = win_prod - 17'(win_quo) * 17'(hss_pkg::WinDiv);
    win_len_d = WinW'(hss_pkg::WinBase) + win_quo
              + WinW'(win_rem >= 17'(hss_pkg::WinDiv));
  end

  always_comb begin
    phase_d    = phase_q;
    step_d     = step_q;
    col_d      = col_q;
    row_d      = row_q;
    lit_cnt_d  = lit_cnt_q;
    data_d     = data_q;
    latch_d    = latch_q;
    blank_d    = blank_q;
    clk_pulse  = 1'b0;
    lat_pulse  = 1'b0;
    frame_done = 1'b0;
    rejected   = 1'b0;
    col_inc    = col_q + ColW'(1);
    row_inc    = {1'b0, row_q} + (RowW+1)'(1);
    lit_dec    = (lit_cnt_q != '0) ? lit_cnt_q - WinW'(1) : '0;
    step_rel   = step_q - StepW'(hss_pkg::ROW_LENGTH);

    case (in_item_i.action)
      hss_pkg::ActShift: begin
        if (phase_q == PhShift) begin
          data_d    = {in_item_i.upper_color, in_item_i.lower_color};
          clk_pulse = 1'b1;
          col_d     = col_inc;
          if (col_inc >= ColW'(hss_pkg::ROW_LENGTH)) begin
            phase_d = PhFull;
          end
        end else begin
          rejected = 1'b1;
        end
      end
      hss_pkg::ActTick: begin
        case (phase_q)
          PhInit: begin
            step_d = step_q + StepW'(1);
            if (step_q < StepW'(hss_pkg::ROW_LENGTH)) begin
              data_d    = hss_pkg::RegOnePattern[step_q[3:0]] ? 6'h3F : 6'h00;
              latch_d   = step_q >= StepW'(hss_pkg::ROW_LENGTH - 11);
              clk_pulse = 1'b1;
            end else if (step_q < StepW'(2 * hss_pkg::ROW_LENGTH)) begin
              data_d    = hss_pkg::RegTwoPattern[step_rel[3:0]] ? 6'h3F : 6'h00;
              latch_d   = step_rel >= StepW'(hss_pkg::ROW_LENGTH - 12);
              clk_pulse = 1'b1;
            end else if (step_q < StepW'(3 * hss_pkg::ROW_LENGTH)) begin
              data_d    = 6'h00;
              latch_d   = 1'b0;
              clk_pulse = 1'b1;
            end else begin
              latch_d   = 1'b0;
              lat_pulse = 1'b1;
              phase_d   = PhShift;
              col_d     = '0;
              step_d    = '0;
            end
          end
          PhFull: begin
            latch_d   = 1'b0;
            lat_pulse = 1'b1;
            blank_d   = 1'b0;
            lit_cnt_d = win_len_q;
            phase_d   = PhLit;
          end
          PhLit: begin
            lit_cnt_d = lit_dec;
            if (lit_dec == '0) begin
              blank_d = 1'b1;
              col_d   = '0;
              phase_d = PhShift;
              if (row_inc >= (RowW+1)'(hss_pkg::ROW_COUNT)) begin
                row_d      = '0;
                frame_done = 1'b1;
              end else begin
                row_d = row_inc[RowW-1:0];
              end
            end
          end
          default: begin
            // Shifting phase: tick is taken, nothing moves.
          end
        endcase
      end
      hss_pkg::ActInit: begin
        if (phase_q == PhShift) begin
          blank_d = 1'b1;
          latch_d = 1'b0;
          step_d  = '0;
          col_d   = '0;
          phase_d = PhInit;
        end else begin
          rejected = 1'b1;
        end
      end
      default: begin
        rejected = 1'b1;
      end
    endcase

    out_item_d.upper_rgb    = data_d[5:3];
    out_item_d.lower_rgb    = data_d[2:0];
    out_item_d.row_address  = row_d;
    out_item_d.clock_pulse  = clk_pulse;
    out_item_d.latch_level  = latch_d;
    out_item_d.latch_pulse  = lat_pulse;
    out_item_d.output_blank = blank_d;
    out_item_d.phase        = phase_d;
    out_item_d.frame_done   = frame_done;
    out_item_d.rejected     = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhShift;
      step_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      lit_cnt_q   <= '0;
      data_q      <= '0;
      latch_q     <= 1'b0;
      blank_q     <= 1'b1;
      win_len_q   <= hss_pkg::WinResetLen;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_len_q <= win_len_d;
      end
      if (accept) begin
        phase_q     <= phase_d;
        step_q      <= step_d;
        col_q       <= col_d;
        row_q       <= row_d;
        lit_cnt_q   <= lit_cnt_d;
        data_q      <= data_d;
        latch_q     <= latch_d;
        blank_q     <= blank_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        // Drop the result once it has been taken.
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  `HSS_ASSERT_NOW(a_lit_only_when_unblanked, !blank_q, phase_q == PhLit, "panel lit outside lit phase")
  `HSS_ASSERT_NOW(a_init_blanked, phase_q == PhInit, blank_q, "panel unblanked during init")
  `HSS_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_q, "input stalled with no held result")
  `HSS_ASSERT_NEXT(a_reject_holds_phase, accept && rejected, phase_q == $past(phase_q), "rejected item changed phase")
  `HSS_ASSERT_NEXT(a_frame_wraps_row, accept && frame_done, row_q == '0, "frame done without row wrap")

endmodule
